// ===== rtl/core/selection_sort_by_key_top_macros.svh =====
// ----------------------------------------------------------------------------
// selection sort by key - assertion macros
// property shorthands used by the sorter controller rtl
// ----------------------------------------------------------------------------
`ifndef SELECTION_SORT_BY_KEY_TOP_MACROS_SVH
`define SELECTION_SORT_BY_KEY_TOP_MACROS_SVH

// same-cycle implication
`define SSK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ssk_pkg.sv =====
// ----------------------------------------------------------------------------
// ssk_pkg
// record type, controller states and key compare for the sorter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssk_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned TagW = 16;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        tag;
  } rec_t;

  typedef enum logic [1:0] {
    StLoad,
    StFetch,
    StScan,
    StEmit
  } state_e;

  // true when key a displaces the current best key b
  function automatic logic key_before(input logic signed [KeyW-1:0] a,
                                      input logic signed [KeyW-1:0] b,
                                      input logic desc);
    logic res;
    if (desc) begin
      res = (a > b);
    end else begin
      res = (a < b);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/ssk_mem.sv =====
// ----------------------------------------------------------------------------
// ssk_mem
// record memory, one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssk_mem import ssk_pkg::*; #(
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  rec_t             wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output rec_t             rdata_o
);

  rec_t mem_q [Depth];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ssk_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssk_ctrl
// load sequencer and selection sort scan over the record memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "selection_sort_by_key_top_macros.svh"

module ssk_ctrl import ssk_pkg::*; #(
  parameter int unsigned MaxRecords = 64,
  localparam int unsigned AddrW = $clog2(MaxRecords),
  localparam int unsigned CntW = $clog2(MaxRecords + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [KeyW-1:0] sort_key_i,
  input  logic [TagW-1:0]        payload_tag_i,
  input  logic                   last_item_i,
  input  logic                   desc_i,
  output logic                   busy_o,
  output logic                   mem_we_o,
  output logic [AddrW-1:0]       mem_waddr_o,
  output rec_t                   mem_wdata_o,
  output logic [AddrW-1:0]       mem_raddr_o,
  input  rec_t                   mem_rdata_i,
  output logic                   result_valid_o,
  output logic signed [KeyW-1:0] sorted_key_o,
  output logic [TagW-1:0]        sorted_tag_o,
  output logic                   last_result_o,
  output logic                   overflowed_o
);

  state_e state_q, state_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [CntW-1:0] best_idx_q, best_idx_d;
  logic            ovf_q, ovf_d;
  rec_t            cur_q, cur_d;
  rec_t            best_q, best_d;

  logic            has_room;
  logic            pos_last;

  assign has_room = (cnt_q < CntW'(MaxRecords));
  assign pos_last = (CntW'(i_q + 1'b1) == n_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad: begin
        if (start_i && last_item_i) begin
          state_d = StFetch;
        end
      end
      StFetch: begin
        state_d = StScan;
      end
      StScan: begin
        if (rd_idx_q == CntW'(n_q - 1'b1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        state_d = pos_last ? StLoad : StFetch;
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // datapath and memory access
  always_comb begin
    cnt_d       = cnt_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    rd_idx_d    = rd_idx_q;
    best_idx_d  = best_idx_q;
    ovf_d       = ovf_q;
    cur_d       = cur_q;
    best_d      = best_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[AddrW-1:0];
    mem_wdata_o = '{key: sort_key_i, tag: payload_tag_i};
    mem_raddr_o = j_q[AddrW-1:0];
    case (state_q)
      StLoad: begin
        if (start_i) begin
          if (has_room) begin
            mem_we_o = 1'b1;
            cnt_d    = CntW'(cnt_q + 1'b1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_item_i) begin
            n_d = has_room ? CntW'(cnt_q + 1'b1) : cnt_q;
            i_d = '0;
          end
        end
      end
      StFetch: begin
        mem_raddr_o = i_q[AddrW-1:0];
        rd_idx_d    = i_q;
        j_d         = CntW'(i_q + 1'b1);
      end
      StScan: begin
        mem_raddr_o = j_q[AddrW-1:0];
        rd_idx_d    = j_q;
        if (j_q != n_q) begin
          j_d = CntW'(j_q + 1'b1);
        end
        if (rd_idx_q == i_q) begin
          cur_d      = mem_rdata_i;
          best_d     = mem_rdata_i;
          best_idx_d = i_q;
        end else if (key_before(mem_rdata_i.key, best_q.key, desc_i)) begin
          best_d     = mem_rdata_i;
          best_idx_d = rd_idx_q;
        end
      end
      StEmit: begin
        // displaced record moves into the slot the winner left
        mem_we_o    = 1'b1;
        mem_waddr_o = best_idx_q[AddrW-1:0];
        mem_wdata_o = cur_q;
        i_d         = CntW'(i_q + 1'b1);
        if (pos_last) begin
          cnt_d = '0;
          ovf_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    busy_o         = (state_q != StLoad);
    result_valid_o = (state_q == StEmit);
    sorted_key_o   = best_q.key;
    sorted_tag_o   = best_q.tag;
    last_result_o  = pos_last;
    overflowed_o   = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      n_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      n_q     <= n_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q        <= j_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    cur_q      <= cur_d;
    best_q     <= best_d;
  end

  `SSK_ASSERT_NEXT(a_last_word_idle, result_valid_o && last_result_o, !busy_o,
                   "busy after final word")
  `SSK_ASSERT_IMPL(a_best_in_range, state_q == StEmit,
                   (best_idx_q >= i_q) && (best_idx_q < n_q), "winner index out of range")
  `SSK_ASSERT_IMPL(a_cnt_cap, 1'b1, cnt_q <= CntW'(MaxRecords), "record count over capacity")
  `SSK_ASSERT_IMPL(a_scan_in_set, state_q == StScan, (rd_idx_q < n_q) && (n_q != '0),
                   "scan read outside set")

endmodule

// ===== rtl/core/selection_sort_by_key_top.sv =====
// ----------------------------------------------------------------------------
// selection_sort_by_key_top
// loads a record set, selection sorts it by signed key, streams it out
// ----------------------------------------------------------------------------
// usage:
//   a word (sort_key_i, payload_tag_i, last_item_i) is taken when start_i is
//   high and busy_o is low; one word per cycle while loading, MAX_RECORDS kept
//   per set, further words dropped and the set flagged overflowed
//   a word with last_item_i set starts the sort; busy_o stays high until the
//   final sorted word has gone out
//   sorted words appear on sorted_*_o for one cycle each, marked by
//   result_valid_o; last_result_o marks the final one
//   for n records position i takes an address fetch, then one memory read
//   per remaining record, then one emit with write-back of the swap; the
//   remaining records are read one at a time, in order of address;
//   the single read port of the record memory sets this
//   cfg_valid_i / cfg_ready_o / cfg_data_i write the sort order (1 = descending),
//   always ready, to be written only while idle
//   reset empties the set, clears the overflow flag and selects ascending order
//   the receiver cannot stall; results are never held
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module selection_sort_by_key_top import ssk_pkg::*; #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic signed [KeyW-1:0] sort_key_i,
  input  logic [TagW-1:0]        payload_tag_i,
  input  logic                   last_item_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i,
  output logic                   result_valid_o,
  output logic signed [KeyW-1:0] sorted_key_o,
  output logic [TagW-1:0]        sorted_tag_o,
  output logic                   last_result_o,
  output logic                   overflowed_o
);

  localparam int unsigned AddrW = $clog2(MAX_RECORDS);

  logic             desc_q, desc_d;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_raddr;
  rec_t             mem_wdata;
  rec_t             mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    desc_d = desc_q;
    if (cfg_valid_i && cfg_ready_o) begin
      desc_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else begin
      desc_q <= desc_d;
    end
  end

  ssk_ctrl #(
    .MaxRecords (MAX_RECORDS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .sort_key_i     (sort_key_i),
    .payload_tag_i  (payload_tag_i),
    .last_item_i    (last_item_i),
    .desc_i         (desc_q),
    .busy_o         (busy_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .result_valid_o (result_valid_o),
    .sorted_key_o   (sorted_key_o),
    .sorted_tag_o   (sorted_tag_o),
    .last_result_o  (last_result_o),
    .overflowed_o   (overflowed_o)
  );

  ssk_mem #(
    .Depth (MAX_RECORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== bench/selection_sort_by_key_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selection_sort_by_key_top_tb
// drives record sets into the sorter and checks every sorted word against
// an in-bench selection sort; covers both sort orders, key extremes, ties,
// full and overflowing sets, with and without sender gaps
// ----------------------------------------------------------------------------

module selection_sort_by_key_top_tb import ssk_pkg::*; ();

  localparam int unsigned MAX_RECORDS    = 64;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = MAX_RECORDS + 8;
  localparam int unsigned MAX_PRINTED    = 40;
  localparam int unsigned PHASE_ITEMS    = 20;

  localparam logic signed [KeyW-1:0] KEY_MIN = {1'b1, {(KeyW-1){1'b0}}};
  localparam logic signed [KeyW-1:0] KEY_MAX = {1'b0, {(KeyW-1){1'b1}}};

  typedef enum int unsigned {
    KeyFull,
    KeyNarrow,
    KeyEdge
  } key_mode_e;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        tag;
    logic                   last;
    logic                   drain_first;
  } sort_word_t;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        tag;
    logic                   last;
    logic                   ovf;
  } sorted_word_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   start_i        = 1'b0;
  logic                   busy_o;
  logic signed [KeyW-1:0] sort_key_i     = '0;
  logic [TagW-1:0]        payload_tag_i  = '0;
  logic                   last_item_i    = 1'b0;
  logic                   cfg_valid_i    = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_data_i     = 1'b0;
  logic                   result_valid_o;
  logic signed [KeyW-1:0] sorted_key_o;
  logic [TagW-1:0]        sorted_tag_o;
  logic                   last_result_o;
  logic                   overflowed_o;

  sort_word_t   word_q[$];
  sorted_word_t sorted_q[$];

  // bench copy of the record set and sort order
  logic signed [KeyW-1:0] key_mem [MAX_RECORDS];
  logic [TagW-1:0]        tag_mem [MAX_RECORDS];
  int unsigned            rec_count      = 0;
  bit                     set_dropped    = 1'b0;
  bit                     order_desc     = 1'b0;

  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned gap_pct        = 0;
  int unsigned err_count      = 0;
  int unsigned stall_cycles   = 0;

  selection_sort_by_key_top #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .sort_key_i    (sort_key_i),
    .payload_tag_i (payload_tag_i),
    .last_item_i   (last_item_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .sorted_key_o  (sorted_key_o),
    .sorted_tag_o  (sorted_tag_o),
    .last_result_o (last_result_o),
    .overflowed_o  (overflowed_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [KeyW-1:0] got,
                                 input logic [KeyW-1:0] want);
    if (err_count < MAX_PRINTED) begin
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  function automatic void sort_records(input int unsigned n);
    int unsigned            best;
    logic signed [KeyW-1:0] k;
    logic [TagW-1:0]        t;
    for (int unsigned i = 0; i < n; i++) begin
      best = i;
      for (int unsigned j = i + 1; j < n; j++) begin
        if (order_desc ? (key_mem[j] > key_mem[best]) : (key_mem[j] < key_mem[best])) begin
          best = j;
        end
      end
      if (best != i) begin
        k             = key_mem[i];
        t             = tag_mem[i];
        key_mem[i]    = key_mem[best];
        tag_mem[i]    = tag_mem[best];
        key_mem[best] = k;
        tag_mem[best] = t;
      end
    end
  endfunction

  task automatic load_record(input logic signed [KeyW-1:0] key, input logic [TagW-1:0] tag,
                             input logic last);
    sorted_word_t res;
    if (rec_count < MAX_RECORDS) begin
      key_mem[rec_count] = key;
      tag_mem[rec_count] = tag;
      rec_count++;
    end else begin
      set_dropped = 1'b1;
    end
    accepted_count++;
    if (last) begin
      sort_records(rec_count);
      for (int unsigned k = 0; k < rec_count; k++) begin
        res.key  = key_mem[k];
        res.tag  = tag_mem[k];
        res.last = (k + 1 == rec_count);
        res.ovf  = set_dropped;
        sorted_q.push_back(res);
      end
      rec_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    sort_word_t nxt;
    bit         hold_off;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        load_record(sort_key_i, payload_tag_i, last_item_i);
      end
      if (!(start_i && busy_o)) begin
        hold_off = ($urandom_range(99) < gap_pct);
        if (word_q.size() != 0 && word_q[0].drain_first &&
            (sorted_q.size() != 0 || busy_o)) begin
          hold_off = 1'b1;
        end
        if (word_q.size() != 0 && !hold_off) begin
          nxt = word_q.pop_front();
          start_i       <= 1'b1;
          sort_key_i    <= nxt.key;
          payload_tag_i <= nxt.tag;
          last_item_i   <= nxt.last;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    sorted_word_t want;
    if (rst_ni && result_valid_o) begin
      if (sorted_q.size() == 0) begin
        report_mismatch("word with nothing expected", sorted_key_o, '0);
      end else begin
        want = sorted_q.pop_front();
        if (sorted_key_o !== want.key) begin
          report_mismatch("sorted_key", sorted_key_o, want.key);
        end
        if (sorted_tag_o !== want.tag) begin
          report_mismatch("sorted_tag", KeyW'(sorted_tag_o), KeyW'(want.tag));
        end
        if (last_result_o !== want.last) begin
          report_mismatch("last_result", KeyW'(last_result_o), KeyW'(want.last));
        end
        if (overflowed_o !== want.ovf) begin
          report_mismatch("overflowed", KeyW'(overflowed_o), KeyW'(want.ovf));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("selection_sort_by_key_top_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic logic signed [KeyW-1:0] pick_key(input key_mode_e mode);
    logic signed [KeyW-1:0] key;
    case (mode)
      KeyNarrow: begin
        key = $urandom_range(6);
        key = key - 3;
      end
      KeyEdge: begin
        case ($urandom_range(5))
          0:       key = KEY_MIN;
          1:       key = KEY_MAX;
          2:       key = '0;
          3:       key = '1;
          4:       key = KEY_MIN + 1;
          default: key = KEY_MAX - 1;
        endcase
      end
      default: begin
        key = $urandom;
      end
    endcase
    return key;
  endfunction

  task automatic push_word(input logic signed [KeyW-1:0] key, input logic [TagW-1:0] tag,
                           input logic last, input logic drain);
    sort_word_t w;
    w.key         = key;
    w.tag         = tag;
    w.last        = last;
    w.drain_first = drain;
    word_q.push_back(w);
    queued_count++;
  endtask

  task automatic queue_set(input int unsigned n, input key_mode_e mode, input bit drain);
    for (int unsigned i = 0; i < n; i++) begin
      push_word(pick_key(mode), 16'($urandom_range(65535)), i == n - 1, drain && i == 0);
    end
  endtask

  task automatic wait_quiet();
    while (accepted_count != queued_count || sorted_q.size() != 0 || busy_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_sort_order(input bit desc);
    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_data_i  <= desc;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    order_desc = desc;
  endtask

  initial begin
    int unsigned n;
    int unsigned phase_items;
    int unsigned set_idx;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ascending from reset: single record, then extremes with tied keys
    push_word(KEY_MIN, 16'h0000, 1'b1, 1'b0);
    push_word('0, 16'hffff, 1'b0, 1'b0);
    push_word(KEY_MAX, 16'h0001, 1'b0, 1'b0);
    push_word(KEY_MIN, 16'h0002, 1'b0, 1'b0);
    push_word('1, 16'h0003, 1'b0, 1'b0);
    push_word(KEY_MAX, 16'h0004, 1'b0, 1'b0);
    push_word(1, 16'h0005, 1'b0, 1'b0);
    push_word('0, 16'h0006, 1'b1, 1'b0);

    // descending: extreme keys, ties on both ends, single and equal-key pairs
    write_sort_order(1'b1);
    push_word(KEY_MIN, 16'h8000, 1'b0, 1'b0);
    push_word(KEY_MAX, 16'h7fff, 1'b0, 1'b0);
    push_word('0, 16'h00ff, 1'b0, 1'b0);
    push_word(KEY_MIN, 16'hff00, 1'b0, 1'b0);
    push_word(KEY_MAX, 16'h5555, 1'b0, 1'b0);
    push_word('1, 16'haaaa, 1'b0, 1'b0);
    push_word('0, 16'h1234, 1'b1, 1'b0);
    push_word(KEY_MAX, 16'hffff, 1'b1, 1'b0);
    push_word(5, 16'h000a, 1'b0, 1'b0);
    push_word(5, 16'h000b, 1'b1, 1'b0);

    for (int unsigned p = 0; p < 4; p++) begin
      write_sort_order(p % 2 == 1);
      gap_pct     = (p == 1) ? 52 : (p == 3) ? 33 : 0;
      phase_items = 0;
      set_idx     = 0;
      // a full set without loss, then a set that overflows and drops its last three words
      if (p == 0) begin
        queue_set(MAX_RECORDS, KeyFull, 1'b0);
        phase_items += MAX_RECORDS;
        set_idx++;
      end
      if (p == 2) begin
        queue_set(MAX_RECORDS + 3, KeyNarrow, 1'b0);
        phase_items += MAX_RECORDS + 3;
        set_idx++;
      end
      while (phase_items < PHASE_ITEMS || set_idx < 2) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        queue_set(n, key_mode_e'($urandom_range(2)), set_idx == 1 || $urandom_range(4) == 0);
        phase_items += n;
        set_idx++;
      end
    end

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("selection_sort_by_key_top_tb: done, clean");
    end else begin
      $display("selection_sort_by_key_top_tb: done, errors");
    end
    $finish;
  end

endmodule
